### rtl/lesd_pkg.sv
package lesd_pkg;

  // Position width of the hook and pallet channels and the limit registers
  localparam int unsigned POSITION_BITS = 8;
  localparam int unsigned POS_EXT_BITS  = POSITION_BITS + 1;
  localparam int unsigned COUNT_BITS    = 7;
  localparam int unsigned SENSOR_BITS   = 8;
  localparam int unsigned STATUS_BITS   = 2;

  // Input tdata layout, lowest bit first
  localparam int unsigned IN_HOOK_LSB    = 0;
  localparam int unsigned IN_PALLET_LSB  = IN_HOOK_LSB + POSITION_BITS;
  localparam int unsigned IN_SENSOR_LSB  = IN_PALLET_LSB + POSITION_BITS;
  localparam int unsigned IN_NETDOWN_BIT = IN_SENSOR_LSB + SENSOR_BITS;
  localparam int unsigned IN_ALIVE_BIT   = IN_NETDOWN_BIT + 1;
  localparam int unsigned IN_STALE_BIT   = IN_ALIVE_BIT + 1;
  localparam int unsigned IN_USED_BITS   = IN_STALE_BIT + 1;
  localparam int unsigned IN_TDATA_BITS  = ((IN_USED_BITS + 7) / 8) * 8;

  // Output tdata layout, lowest bit first
  localparam int unsigned OUT_HOOK_LSB   = 0;
  localparam int unsigned OUT_PALLET_LSB = OUT_HOOK_LSB + STATUS_BITS;
  localparam int unsigned OUT_ESTOP_BIT  = OUT_PALLET_LSB + STATUS_BITS;
  localparam int unsigned OUT_USED_BITS  = OUT_ESTOP_BIT + 1;
  localparam int unsigned OUT_TDATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

  // Window and tick thresholds
  localparam logic [POSITION_BITS-1:0] NEAR_WINDOW     = POSITION_BITS'(5);
  localparam logic [POS_EXT_BITS-1:0]  NEAR_WINDOW_EXT = POS_EXT_BITS'(5);
  localparam logic [POSITION_BITS-1:0] STILL_WINDOW    = POSITION_BITS'(3);
  localparam logic [COUNT_BITS-1:0]    END_TICKS       = COUNT_BITS'(10);
  localparam logic [COUNT_BITS-1:0]    COUNT_CAP       = COUNT_BITS'(100);

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_BITS = 2;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_HOOK_LOW    = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_HOOK_HIGH   = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_PALLET_LOW  = 2'd2;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_PALLET_HIGH = 2'd3;

  // Limit reset values
  localparam logic [POSITION_BITS-1:0] HOOK_LOW_RST    = POSITION_BITS'(182);
  localparam logic [POSITION_BITS-1:0] HOOK_HIGH_RST   = POSITION_BITS'(254);
  localparam logic [POSITION_BITS-1:0] PALLET_LOW_RST  = POSITION_BITS'(213);
  localparam logic [POSITION_BITS-1:0] PALLET_HIGH_RST = POSITION_BITS'(254);

  // Status codes
  localparam logic [STATUS_BITS-1:0] HOOK_NONE      = 2'd0;
  localparam logic [STATUS_BITS-1:0] HOOK_BLOCKED   = 2'd1;
  localparam logic [STATUS_BITS-1:0] HOOK_LOWER     = 2'd2;
  localparam logic [STATUS_BITS-1:0] HOOK_UPPER     = 2'd3;
  localparam logic [STATUS_BITS-1:0] PALLET_NONE    = 2'd0;
  localparam logic [STATUS_BITS-1:0] PALLET_LOWER   = 2'd1;
  localparam logic [STATUS_BITS-1:0] PALLET_UPPER   = 2'd2;

  // Per-item control handed from the input stage to the trackers
  typedef struct packed {
    logic advance;
  } step_ctrl_t;

  function automatic logic [POSITION_BITS-1:0] absdiff(
    input logic [POSITION_BITS-1:0] a,
    input logic [POSITION_BITS-1:0] b
  );
    absdiff = (a >= b) ? (a - b) : (b - a);
  endfunction

  // Saturating increment
  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
    bump = (c >= COUNT_CAP) ? COUNT_CAP : (c + COUNT_BITS'(1));
  endfunction

endpackage

### rtl/lift_end_stop_and_stall_detector.sv
// Channel   | Dir | Handshake                    | Payload
// s_axis    | in  | s_axis_tvalid / tready       | hook, pallet, sensor, net down, alive, stale
// m_axis    | out | m_axis_tvalid / tready       | hook status, pallet status, emergency stop
// cfg       | in  | cfg_we_i (no wait)           | cfg_addr_i selects limit, cfg_data_i value
//
// One item per cycle sustained while m_axis_tready is high; an input transaction
// reaches the result through an input register and a result register.
// Reset clears all counters, the hook reference and both valid flags, and loads
// the default limits. A stalled result holds in the result register while one
// more item waits in the input register; counters advance only when an item moves.
module lift_end_stop_and_stall_detector (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // hook_position, pallet_position, sensor_state, link_down, planner_alive,
  // command_stale, zero fill
  input  logic [lesd_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // hook_status, pallet_status, emergency_stop, zero fill
  output logic [lesd_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic [lesd_pkg::CFG_ADDR_BITS-1:0]   cfg_addr_i,
  input  logic [lesd_pkg::POSITION_BITS-1:0]   cfg_data_i
);

  localparam int unsigned P = lesd_pkg::POSITION_BITS;

  logic [P-1:0] hook_low_q, hook_high_q, pallet_low_q, pallet_high_q;

  logic                                in_valid_q;
  logic [lesd_pkg::IN_USED_BITS-1:0]   in_data_q;
  logic                                out_valid_q;
  logic [lesd_pkg::OUT_USED_BITS-1:0]  out_data_q;
  logic [lesd_pkg::OUT_USED_BITS-1:0]  out_data_d;

  logic                                advance;
  lesd_pkg::step_ctrl_t                ctrl;

  logic [P-1:0]                        hook;
  logic [P-1:0]                        pallet;
  logic [lesd_pkg::SENSOR_BITS-1:0]    sensor;
  logic                                net_down, alive, stale, estop;
  logic                                hook_upper, hook_lower, pallet_upper, pallet_lower;
  logic                                blocked;
  logic [lesd_pkg::STATUS_BITS-1:0]    hook_status, pallet_status;

  // Limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hook_low_q    <= lesd_pkg::HOOK_LOW_RST;
      hook_high_q   <= lesd_pkg::HOOK_HIGH_RST;
      pallet_low_q  <= lesd_pkg::PALLET_LOW_RST;
      pallet_high_q <= lesd_pkg::PALLET_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        lesd_pkg::CFG_HOOK_LOW:    hook_low_q    <= cfg_data_i;
        lesd_pkg::CFG_HOOK_HIGH:   hook_high_q   <= cfg_data_i;
        lesd_pkg::CFG_PALLET_LOW:  pallet_low_q  <= cfg_data_i;
        lesd_pkg::CFG_PALLET_HIGH: pallet_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the held item whenever the result register is free or drains
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign ctrl.advance  = advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata[lesd_pkg::IN_USED_BITS-1:0];
    end
  end

  // Unpack the held transaction
  assign hook     = in_data_q[lesd_pkg::IN_HOOK_LSB +: P];
  assign pallet   = in_data_q[lesd_pkg::IN_PALLET_LSB +: P];
  assign sensor   = in_data_q[lesd_pkg::IN_SENSOR_LSB +: lesd_pkg::SENSOR_BITS];
  assign net_down = in_data_q[lesd_pkg::IN_NETDOWN_BIT];
  assign alive    = in_data_q[lesd_pkg::IN_ALIVE_BIT];
  assign stale    = in_data_q[lesd_pkg::IN_STALE_BIT];

  lesd_end_counter u_hook_upper (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .pos_i(hook), .limit_i(hook_low_q),
    .reached_o(hook_upper)
  );

  lesd_end_counter u_hook_lower (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .pos_i(hook), .limit_i(hook_high_q),
    .reached_o(hook_lower)
  );

  lesd_end_counter u_pallet_upper (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .pos_i(pallet), .limit_i(pallet_low_q),
    .reached_o(pallet_upper)
  );

  lesd_end_counter u_pallet_lower (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .pos_i(pallet), .limit_i(pallet_high_q),
    .reached_o(pallet_lower)
  );

  lesd_still_tracker u_still (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .hook_i(hook), .low_limit_i(hook_low_q),
    .high_limit_i(hook_high_q), .blocked_o(blocked)
  );

  // Resolve status: blocked over lower end over upper end
  always_comb begin
    hook_status = lesd_pkg::HOOK_NONE;
    if (hook_upper) hook_status = lesd_pkg::HOOK_UPPER;
    if (hook_lower) hook_status = lesd_pkg::HOOK_LOWER;
    if (blocked)    hook_status = lesd_pkg::HOOK_BLOCKED;
    pallet_status = lesd_pkg::PALLET_NONE;
    if (pallet_upper) pallet_status = lesd_pkg::PALLET_UPPER;
    if (pallet_lower) pallet_status = lesd_pkg::PALLET_LOWER;
  end

  assign estop = (sensor != '0) || net_down || !alive || stale;

  assign out_data_d = {estop, pallet_status, hook_status};

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = lesd_pkg::OUT_TDATA_BITS'(out_data_q);

endmodule

### rtl/lesd_end_counter.sv
module lesd_end_counter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lesd_pkg::step_ctrl_t                ctrl_i,
  input  logic [lesd_pkg::POSITION_BITS-1:0]  pos_i,
  input  logic [lesd_pkg::POSITION_BITS-1:0]  limit_i,
  output logic                                reached_o
);

  logic [lesd_pkg::COUNT_BITS-1:0] count_q;
  logic [lesd_pkg::COUNT_BITS-1:0] count_d;
  logic                            near;

  // Bump while near the limit, clear otherwise
  assign near    = lesd_pkg::absdiff(pos_i, limit_i) < lesd_pkg::NEAR_WINDOW;
  assign count_d = near ? lesd_pkg::bump(count_q) : '0;
  assign reached_o = count_d > lesd_pkg::END_TICKS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.advance) begin
      count_q <= count_d;
    end
  end

endmodule

### rtl/lesd_still_tracker.sv
module lesd_still_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lesd_pkg::step_ctrl_t                ctrl_i,
  input  logic [lesd_pkg::POSITION_BITS-1:0]  hook_i,
  input  logic [lesd_pkg::POSITION_BITS-1:0]  low_limit_i,
  input  logic [lesd_pkg::POSITION_BITS-1:0]  high_limit_i,
  output logic                                blocked_o
);

  logic [lesd_pkg::POSITION_BITS-1:0] ref_q;
  logic [lesd_pkg::POSITION_BITS-1:0] ref_d;
  logic [lesd_pkg::COUNT_BITS-1:0]    still_q;
  logic [lesd_pkg::COUNT_BITS-1:0]    still_d;
  logic [lesd_pkg::POS_EXT_BITS-1:0]  hook_ext;
  logic [lesd_pkg::POS_EXT_BITS-1:0]  mid_lo;
  logic [lesd_pkg::POS_EXT_BITS-1:0]  hook_plus;
  logic                               mid;
  logic                               moved;

  // Mid range: low + window <= hook <= high - window, compared without underflow
  assign hook_ext  = {1'b0, hook_i};
  assign mid_lo    = {1'b0, low_limit_i} + lesd_pkg::NEAR_WINDOW_EXT;
  assign hook_plus = hook_ext + lesd_pkg::NEAR_WINDOW_EXT;
  assign mid       = (hook_ext >= mid_lo) && (hook_plus <= {1'b0, high_limit_i});
  assign moved     = lesd_pkg::absdiff(hook_i, ref_q) > lesd_pkg::STILL_WINDOW;

  // Re-anchor on movement, count still ticks, clear outside the mid range
  always_comb begin
    ref_d   = ref_q;
    still_d = '0;
    if (mid) begin
      if (moved) begin
        ref_d = hook_i;
      end else begin
        still_d = lesd_pkg::bump(still_q);
      end
    end
  end

  assign blocked_o = mid && (still_d > lesd_pkg::END_TICKS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q   <= '0;
      still_q <= '0;
    end else if (ctrl_i.advance) begin
      ref_q   <= ref_d;
      still_q <= still_d;
    end
  end

endmodule

### verif/lift_status_checker.sv
`timescale 1ns / 1ps

module lift_status_checker
  import lesd_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  // hook_position, pallet_position, sensor_state, link_down, planner_alive,
  // command_stale, zero fill
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // hook_status, pallet_status, emergency_stop, zero fill
  input  logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
  input  logic                      cfg_we_i,
  input  logic [CFG_ADDR_BITS-1:0]  cfg_addr_i,
  input  logic [POSITION_BITS-1:0]  cfg_data_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        checked_o
);

  localparam int NEAR_DIST  = 5;
  localparam int END_LIMIT  = 10;
  localparam int SAT_LIMIT  = 100;
  localparam int STILL_DIST = 3;

  typedef struct packed {
    logic [STATUS_BITS-1:0] hook;
    logic [STATUS_BITS-1:0] pallet;
    logic                   estop;
  } lift_status_t;

  // Limits as last written
  logic [POSITION_BITS-1:0] hook_low_lim;
  logic [POSITION_BITS-1:0] hook_high_lim;
  logic [POSITION_BITS-1:0] pallet_low_lim;
  logic [POSITION_BITS-1:0] pallet_high_lim;

  // Dwell counters and the stall anchor
  logic [COUNT_BITS-1:0]    hook_upper_ticks;
  logic [COUNT_BITS-1:0]    hook_lower_ticks;
  logic [COUNT_BITS-1:0]    pallet_upper_ticks;
  logic [COUNT_BITS-1:0]    pallet_lower_ticks;
  logic [COUNT_BITS-1:0]    hook_still_ticks;
  logic [POSITION_BITS-1:0] hook_anchor;

  lift_status_t expected_status_q[$];
  int           fail_count;
  int           checked;

  function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] c);
    return (int'(c) >= SAT_LIMIT) ? COUNT_BITS'(SAT_LIMIT) : c + COUNT_BITS'(1);
  endfunction

  function automatic int pos_dist(input logic [POSITION_BITS-1:0] a,
                                  input logic [POSITION_BITS-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  // Bump while inside the window around a limit, clear otherwise
  function automatic logic [COUNT_BITS-1:0] dwell_count(input logic [COUNT_BITS-1:0] c,
                                                        input logic [POSITION_BITS-1:0] pos,
                                                        input logic [POSITION_BITS-1:0] lim);
    return (pos_dist(pos, lim) < NEAR_DIST) ? count_up(c) : '0;
  endfunction

  // Advance the tracked state by one tick and return the status it reports
  function automatic lift_status_t predict_lift_status(input logic [IN_TDATA_BITS-1:0] d);
    logic [POSITION_BITS-1:0] hook;
    logic [POSITION_BITS-1:0] pallet;
    lift_status_t             r;
    hook   = d[IN_HOOK_LSB +: POSITION_BITS];
    pallet = d[IN_PALLET_LSB +: POSITION_BITS];
    r.estop = (|d[IN_SENSOR_LSB +: SENSOR_BITS]) || d[IN_NETDOWN_BIT] ||
              !d[IN_ALIVE_BIT] || d[IN_STALE_BIT];
    r.hook   = HOOK_NONE;
    r.pallet = PALLET_NONE;

    // Later ends override earlier ones
    hook_upper_ticks = dwell_count(hook_upper_ticks, hook, hook_low_lim);
    if (int'(hook_upper_ticks) > END_LIMIT) r.hook = HOOK_UPPER;
    hook_lower_ticks = dwell_count(hook_lower_ticks, hook, hook_high_lim);
    if (int'(hook_lower_ticks) > END_LIMIT) r.hook = HOOK_LOWER;
    pallet_upper_ticks = dwell_count(pallet_upper_ticks, pallet, pallet_low_lim);
    if (int'(pallet_upper_ticks) > END_LIMIT) r.pallet = PALLET_UPPER;
    pallet_lower_ticks = dwell_count(pallet_lower_ticks, pallet, pallet_high_lim);
    if (int'(pallet_lower_ticks) > END_LIMIT) r.pallet = PALLET_LOWER;

    // Stall tracking only inside the mid range; the anchor survives leaving it
    if (int'(hook) >= int'(hook_low_lim) + NEAR_DIST &&
        int'(hook) <= int'(hook_high_lim) - NEAR_DIST) begin
      if (pos_dist(hook, hook_anchor) > STILL_DIST) begin
        hook_anchor      = hook;
        hook_still_ticks = '0;
      end else begin
        hook_still_ticks = count_up(hook_still_ticks);
      end
      if (int'(hook_still_ticks) > END_LIMIT) r.hook = HOOK_BLOCKED;
    end else begin
      hook_still_ticks = '0;
    end
    return r;
  endfunction

  task automatic field_check(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin : watch
    lift_status_t got;
    lift_status_t want;
    if (!rst_ni) begin
      hook_low_lim       = HOOK_LOW_RST;
      hook_high_lim      = HOOK_HIGH_RST;
      pallet_low_lim     = PALLET_LOW_RST;
      pallet_high_lim    = PALLET_HIGH_RST;
      hook_upper_ticks   = '0;
      hook_lower_ticks   = '0;
      pallet_upper_ticks = '0;
      pallet_lower_ticks = '0;
      hook_still_ticks   = '0;
      hook_anchor        = '0;
      expected_status_q.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_HOOK_LOW:    hook_low_lim    = cfg_data_i;
          CFG_HOOK_HIGH:   hook_high_lim   = cfg_data_i;
          CFG_PALLET_LOW:  pallet_low_lim  = cfg_data_i;
          CFG_PALLET_HIGH: pallet_high_lim = cfg_data_i;
          default: ;
        endcase
      end

      // Compare the result transaction before queuing this edge's input
      if (m_axis_tvalid && m_axis_tready) begin
        got.hook   = m_axis_tdata[OUT_HOOK_LSB +: STATUS_BITS];
        got.pallet = m_axis_tdata[OUT_PALLET_LSB +: STATUS_BITS];
        got.estop  = m_axis_tdata[OUT_ESTOP_BIT];
        if (expected_status_q.size() == 0) begin
          $display("%0t: result with nothing pending, expected none, actual %h",
                   $time, m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_status_q.pop_front();
          field_check("hook_status", int'(want.hook), int'(got.hook));
          field_check("pallet_status", int'(want.pallet), int'(got.pallet));
          field_check("emergency_stop", int'(want.estop), int'(got.estop));
          checked++;
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        expected_status_q.push_back(predict_lift_status(s_axis_tdata));
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_status_q.size();
    checked_o    <= checked;
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import lesd_pkg::*;

  localparam int NEAR_DIST = 5;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic                      cfg_we_i      = 1'b0;
  logic [CFG_ADDR_BITS-1:0]  cfg_addr_i    = CFG_HOOK_LOW;
  logic [POSITION_BITS-1:0]  cfg_data_i    = '0;

  logic no_idle    = 1'b0;
  int   stall_left = 0;
  int   fail_count;
  int   pending;
  int   checked;
  int   ticks_sent    = 0;
  int   settings_used = 1;

  // Limits in force, used to aim the stimulus
  int lim_hook_low    = int'(HOOK_LOW_RST);
  int lim_hook_high   = int'(HOOK_HIGH_RST);
  int lim_pallet_low  = int'(PALLET_LOW_RST);
  int lim_pallet_high = int'(PALLET_HIGH_RST);

  lift_end_stop_and_stall_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  lift_status_checker status_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Run stalled: %0d ticks sent, %0d results pending", ticks_sent, pending);
    $display("FAIL lift_end_stop_and_stall_detector");
    $finish;
  end

  // Stall the result side in short bursts
  always @(posedge clk_i) begin
    if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic int clamp_pos(input int v);
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  // Offset within +-w, now and then a little wider to break a dwell
  function automatic int jitter(input int w);
    int j;
    j = ($urandom_range(0, 9) == 0) ? w + 2 : w;
    return int'($urandom_range(0, 2 * j)) - j;
  endfunction

  // Offer one tick, with an occasional gap first, and hold until accepted
  task automatic send_tick(input int hook, input int pallet, input int sensor,
                           input bit net_down, input bit alive, input bit stale);
    logic [IN_TDATA_BITS-1:0] d;
    d = '0;
    d[IN_HOOK_LSB +: POSITION_BITS]   = hook[POSITION_BITS-1:0];
    d[IN_PALLET_LSB +: POSITION_BITS] = pallet[POSITION_BITS-1:0];
    d[IN_SENSOR_LSB +: SENSOR_BITS]   = sensor[SENSOR_BITS-1:0];
    d[IN_NETDOWN_BIT]                 = net_down;
    d[IN_ALIVE_BIT]                   = alive;
    d[IN_STALE_BIT]                   = stale;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    ticks_sent++;
  endtask

  // Drop valid and hold until every result has come back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limits(input int hl, input int hh, input int pl, input int ph);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= CFG_HOOK_LOW;
    cfg_data_i <= hl[POSITION_BITS-1:0];
    @(posedge clk_i);
    cfg_addr_i <= CFG_HOOK_HIGH;
    cfg_data_i <= hh[POSITION_BITS-1:0];
    @(posedge clk_i);
    cfg_addr_i <= CFG_PALLET_LOW;
    cfg_data_i <= pl[POSITION_BITS-1:0];
    @(posedge clk_i);
    cfg_addr_i <= CFG_PALLET_HIGH;
    cfg_data_i <= ph[POSITION_BITS-1:0];
    @(posedge clk_i);
    cfg_we_i        <= 1'b0;
    lim_hook_low    = hl;
    lim_hook_high   = hh;
    lim_pallet_low  = pl;
    lim_pallet_high = ph;
    settings_used++;
  endtask

  // Mostly dwells near a limit or parked mid travel, with some pure noise
  task automatic run_random(input int n_items);
    int kind, len, hook_base, pallet_base, lo, hi, w_hook, w_pallet, h, p;
    int target_sent;
    target_sent = ticks_sent + n_items;
    while (ticks_sent < target_sent) begin
      kind        = $urandom_range(0, 9);
      len         = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 130)
                                                 : $urandom_range(1, 25);
      hook_base   = $urandom_range(0, 1) ? lim_hook_low : lim_hook_high;
      pallet_base = $urandom_range(0, 1) ? lim_pallet_low : lim_pallet_high;
      w_hook      = 4;
      w_pallet    = 4;
      lo          = lim_hook_low + NEAR_DIST;
      hi          = lim_hook_high - NEAR_DIST;
      if (kind >= 3 && kind <= 5) begin
        hook_base = (lo <= hi) ? int'($urandom_range(hi, lo)) : int'($urandom_range(0, 255));
        w_hook    = 3;
      end else if (kind >= 6 && kind <= 7) begin
        w_hook = -1;
      end else if (kind >= 8) begin
        len      = $urandom_range(1, 5);
        w_hook   = -1;
        w_pallet = -1;
      end
      repeat (len) begin
        h = (w_hook < 0) ? int'($urandom_range(0, 255)) : clamp_pos(hook_base + jitter(w_hook));
        p = (w_pallet < 0) ? int'($urandom_range(0, 255))
                           : clamp_pos(pallet_base + jitter(w_pallet));
        if ($urandom_range(0, 3) != 0) begin
          send_tick(h, p, 0, 1'b0, 1'b1, 1'b0);
        end else begin
          send_tick(h, p, $urandom_range(0, 1) ? int'($urandom_range(0, 255)) : 0,
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes, each fault flag alone, window edges at the default limits
    send_tick(0, 0, 0, 1'b0, 1'b1, 1'b0);
    send_tick(255, 255, 255, 1'b1, 1'b0, 1'b1);
    send_tick(100, 100, 8'h01, 1'b0, 1'b1, 1'b0);
    send_tick(100, 100, 8'h80, 1'b0, 1'b1, 1'b0);
    send_tick(100, 100, 0, 1'b1, 1'b1, 1'b0);
    send_tick(100, 100, 0, 1'b0, 1'b0, 1'b0);
    send_tick(100, 100, 0, 1'b0, 1'b1, 1'b1);
    send_tick(177, 208, 0, 1'b0, 1'b1, 1'b0);
    send_tick(178, 209, 0, 1'b0, 1'b1, 1'b0);
    send_tick(186, 217, 0, 1'b0, 1'b1, 1'b0);
    send_tick(187, 218, 0, 1'b0, 1'b1, 1'b0);
    send_tick(249, 249, 0, 1'b0, 1'b1, 1'b0);
    send_tick(250, 250, 0, 1'b0, 1'b1, 1'b0);
    run_random(120);

    // Full-scale limits, then inverted ones with no mid range
    wait_idle();
    write_limits(0, 255, 0, 255);
    run_random(120);
    wait_idle();
    write_limits(255, 0, 255, 0);
    run_random(110);

    // Close limits with overlapping windows, then a narrow mid range
    wait_idle();
    write_limits(100, 104, 60, 62);
    run_random(110);
    wait_idle();
    write_limits(120, 140, 100, 110);
    run_random(110);

    repeat (2) begin
      wait_idle();
      write_limits($urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255));
      run_random(110);
    end

    // Defaults again, with both sides running flat out
    wait_idle();
    write_limits(int'(HOOK_LOW_RST), int'(HOOK_HIGH_RST),
                 int'(PALLET_LOW_RST), int'(PALLET_HIGH_RST));
    no_idle <= 1'b1;
    run_random(120);
    wait_idle();
    repeat (10) @(posedge clk_i);

    $display("Covered %0d ticks under %0d limit settings, %0d results compared",
             ticks_sent, settings_used, checked);
    $display("Dwells at every limit, mid-travel stalls, saturating runs and fault flags");
    if (fail_count == 0) begin
      $display("PASS lift_end_stop_and_stall_detector");
    end else begin
      $display("FAIL lift_end_stop_and_stall_detector");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/lesd_pkg.sv
rtl/lesd_end_counter.sv
rtl/lesd_still_tracker.sv
rtl/lift_end_stop_and_stall_detector.sv
verif/lift_status_checker.sv
verif/tb.sv
